/* sv/pclb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pclb_pkg
// Types and constants shared by the cell list builder modules.
// ----------------------------------------------------------------------------
package pclb_pkg;

  localparam int PID_W   = 12;
  localparam int POS_W   = 24;
  localparam int SCALE_W = 24;
  localparam int BINS_W  = 5;
  localparam int CELL_W  = 4;
  localparam int ENTRY_W = PID_W + 1;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_HEAD   = 2'd2;
  localparam logic [1:0] FUNC_NEXT   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_BINS_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BINS_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BINS_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Z = 3'd5;

  localparam logic [BINS_W-1:0]  BINS_RESET  = 5'd16;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;

  typedef struct packed {
    logic [1:0]         func;
    logic [PID_W-1:0]   particle;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [POS_W-1:0]   pos_z;
  } req_t;

  typedef struct packed {
    logic [PID_W-1:0]  echo_particle;
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic [CELL_W-1:0] cell_z;
    logic [PID_W-1:0]  link;
    logic              link_valid;
    logic              clamped;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic mul;
    logic sat;
    logic addr;
    logic head_rd;
    logic head_res;
    logic head_wr;
    logic next_rd;
    logic next_res;
    logic sweep;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       p_ok;
    logic       ax_last;
    logic       sweep_last;
  } dp_stat_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_MUL,
    ST_SAT,
    ST_ADDR,
    ST_HREAD,
    ST_HDATA,
    ST_NREAD,
    ST_NDATA,
    ST_CLEAR,
    ST_FINISH
  } ctrl_state_t;

endpackage

/* sv/pclb_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pclb_ctrl
// Sequencer for the cell list builder: steps each item through the datapath
// and owns the handshake flags of both item channels.
// ----------------------------------------------------------------------------
module pclb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  input  pclb_pkg::dp_stat_t  stat,
  output pclb_pkg::dp_cmd_t   cmd
);
  import pclb_pkg::*;

  ctrl_state_t state, state_next;
  logic        rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      ST_INIT: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (stat.func)
          FUNC_CLEAR:  state_next = ST_CLEAR;
          FUNC_NEXT:   state_next = stat.p_ok ? ST_NREAD : ST_FINISH;
          FUNC_INSERT: state_next = ST_MUL;
          FUNC_HEAD:   state_next = ST_MUL;
        endcase
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_SAT;
      end
      ST_SAT: begin
        cmd.sat    = 1'b1;
        state_next = stat.ax_last ? ST_ADDR : ST_MUL;
      end
      ST_ADDR: begin
        cmd.addr = 1'b1;
        if (stat.func == FUNC_HEAD || stat.p_ok) state_next = ST_HREAD;
        else state_next = ST_FINISH;
      end
      ST_HREAD: begin
        cmd.head_rd = 1'b1;
        state_next  = ST_HDATA;
      end
      ST_HDATA: begin
        cmd.head_res = 1'b1;
        cmd.head_wr  = (stat.func == FUNC_INSERT);
        state_next   = ST_FINISH;
      end
      ST_NREAD: begin
        cmd.next_rd = 1'b1;
        state_next  = ST_NDATA;
      end
      ST_NDATA: begin
        cmd.next_res = 1'b1;
        state_next   = ST_FINISH;
      end
      ST_CLEAR: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_INIT;
    endcase
  end

  always_comb begin
    if (cmd.load_out) rsp_valid_next = 1'b1;
    else if (rsp_ready) rsp_valid_next = 1'b0;
    else rsp_valid_next = rsp_valid;
  end

endmodule

/* sv/pclb_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pclb_dp
// Datapath: configuration registers, shared bin multiplier, bin address,
// head and link memories, and the result register.
// ----------------------------------------------------------------------------
module pclb_dp #(
  parameter int PARTICLE_COUNT = 4096,
  parameter int AXIS_BINS      = 16,
  parameter int POSITION_BITS  = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pclb_pkg::req_t                      req,
  output pclb_pkg::rsp_t                      rsp,
  input  logic                                cfg_wr,
  input  logic [pclb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pclb_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  pclb_pkg::dp_cmd_t                   cmd,
  output pclb_pkg::dp_stat_t                  stat
);
  import pclb_pkg::*;

  localparam int CW        = (AXIS_BINS > 1) ? $clog2(AXIS_BINS) : 1;
  localparam int BIN_TOTAL = AXIS_BINS * AXIS_BINS * AXIS_BINS;
  localparam int BAW       = (BIN_TOTAL > 1) ? $clog2(BIN_TOTAL) : 1;
  localparam int PAW       = $clog2(PARTICLE_COUNT);
  localparam int PIW       = (PAW > PID_W) ? PAW : PID_W;
  localparam int PW        = (POSITION_BITS < POS_W) ? POSITION_BITS : POS_W;
  localparam logic [POS_W-1:0] POS_MASK = POS_W'((64'(1) << PW) - 64'(1));
  localparam int PROD_W    = POS_W + SCALE_W;

  logic [BINS_W-1:0]  bins_x, bins_y, bins_z;
  logic [SCALE_W-1:0] scale_x, scale_y, scale_z;

  req_t               req_q;
  logic [1:0]         axis;
  logic [PROD_W-1:0]  prod;
  logic [CW-1:0]      coord [3];
  logic               sat_any;
  logic [BAW-1:0]     bin_addr;
  logic [BAW-1:0]     sweep_cnt;
  logic [PID_W-1:0]   res_link;
  logic               res_lv;

  logic [ENTRY_W-1:0] head_mem [BIN_TOTAL];
  logic [ENTRY_W-1:0] next_mem [PARTICLE_COUNT];
  logic [ENTRY_W-1:0] head_q;
  logic [ENTRY_W-1:0] next_q;

  logic [PIW-1:0]     pid;
  logic [PAW-1:0]     paddr;
  logic [POS_W-1:0]   pos_sel;
  logic [SCALE_W-1:0] scale_sel;
  logic [BINS_W-1:0]  bins_sel;
  logic [7:0]         bins_ext;
  logic [7:0]         n_lim;
  logic [15:0]        c_raw;
  logic               c_over;
  logic               geo_func;

  assign pid   = PIW'(req_q.particle);
  assign paddr = pid[PAW-1:0];

  assign stat.func       = req_q.func;
  assign stat.p_ok       = ({1'b0, pid} < (PIW + 1)'(PARTICLE_COUNT));
  assign stat.ax_last    = (axis == 2'd2);
  assign stat.sweep_last = (sweep_cnt == BAW'(BIN_TOTAL - 1));

  always_comb begin
    unique case (axis)
      2'd0: begin
        pos_sel = req_q.pos_x; scale_sel = scale_x; bins_sel = bins_x;
      end
      2'd1: begin
        pos_sel = req_q.pos_y; scale_sel = scale_y; bins_sel = bins_y;
      end
      default: begin
        pos_sel = req_q.pos_z; scale_sel = scale_z; bins_sel = bins_z;
      end
    endcase
  end

  // saturate bin count into 1..AXIS_BINS, then floor and clamp
  always_comb begin
    bins_ext = 8'(bins_sel);
    if (bins_ext == 8'd0) n_lim = 8'd1;
    else if (bins_ext > 8'(AXIS_BINS)) n_lim = 8'(AXIS_BINS);
    else n_lim = bins_ext;
    c_raw  = prod[PROD_W-1:32];
    c_over = (c_raw >= 16'(n_lim));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bins_x  <= BINS_RESET;
      bins_y  <= BINS_RESET;
      bins_z  <= BINS_RESET;
      scale_x <= SCALE_RESET;
      scale_y <= SCALE_RESET;
      scale_z <= SCALE_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_BINS_X:  bins_x  <= cfg_data[BINS_W-1:0];
        REG_BINS_Y:  bins_y  <= cfg_data[BINS_W-1:0];
        REG_BINS_Z:  bins_z  <= cfg_data[BINS_W-1:0];
        REG_SCALE_X: scale_x <= cfg_data[SCALE_W-1:0];
        REG_SCALE_Y: scale_y <= cfg_data[SCALE_W-1:0];
        REG_SCALE_Z: scale_z <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      axis      <= 2'd0;
      sweep_cnt <= '0;
    end else begin
      if (cmd.capture) axis <= 2'd0;
      else if (cmd.sat) axis <= axis + 2'd1;
      if (cmd.sweep) sweep_cnt <= stat.sweep_last ? '0 : sweep_cnt + BAW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q    <= req;
      sat_any  <= 1'b0;
      res_link <= '0;
      res_lv   <= 1'b0;
    end
    if (cmd.mul) prod <= PROD_W'(pos_sel & POS_MASK) * PROD_W'(scale_sel);
    if (cmd.sat) begin
      coord[axis] <= c_over ? CW'(n_lim - 8'd1) : CW'(c_raw);
      if (c_over) sat_any <= 1'b1;
    end
    if (cmd.addr) begin
      bin_addr <= BAW'(32'(coord[0]) + 32'(AXIS_BINS) * 32'(coord[1])
                  + 32'(AXIS_BINS * AXIS_BINS) * 32'(coord[2]));
    end
    if (cmd.head_res) begin
      res_lv   <= head_q[PID_W];
      res_link <= head_q[PID_W] ? head_q[PID_W-1:0] : '0;
    end
    if (cmd.next_res) begin
      res_lv   <= next_q[PID_W];
      res_link <= next_q[PID_W] ? next_q[PID_W-1:0] : '0;
    end
  end

  // head store: sweep writes empty entries, insert pushes the particle
  always_ff @(posedge clk) begin
    if (cmd.sweep) head_mem[sweep_cnt] <= '0;
    else if (cmd.head_wr) head_mem[bin_addr] <= {1'b1, req_q.particle};
    if (cmd.head_rd) head_q <= head_mem[bin_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.head_wr) begin
      next_mem[paddr] <= head_q[PID_W] ? head_q : '0;
    end
    if (cmd.next_rd) next_q <= next_mem[paddr];
  end

  assign geo_func = (req_q.func == FUNC_INSERT) || (req_q.func == FUNC_HEAD);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp.echo_particle <= (req_q.func == FUNC_CLEAR) ? '0 : req_q.particle;
      rsp.cell_x        <= geo_func ? CELL_W'(coord[0]) : '0;
      rsp.cell_y        <= geo_func ? CELL_W'(coord[1]) : '0;
      rsp.cell_z        <= geo_func ? CELL_W'(coord[2]) : '0;
      rsp.clamped       <= geo_func & sat_any;
      rsp.link          <= res_link;
      rsp.link_valid    <= res_lv;
    end
  end

endmodule

/* sv/particle_cell_list_builder.sv */
`timescale 1ns / 1ps
// One item at a time: insert and head lookup run the multiply and saturate steps
// for each axis, then the bin address and the head read; next lookup reads the
// link store; clear sweeps the head store. One shared multiplier does the three
// axes in turn, and the head store sweeps one bin a cycle on clear.
// Reset: synchronous; a sweep over all AXIS_BINS^3 bins empties them, with
// req_ready low; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// particle_cell_list_builder
// Cell list binning: insert, head lookup, next lookup and clear over a grid
// of bins, with a configurable bin count and scale per axis.
// ----------------------------------------------------------------------------
module particle_cell_list_builder #(
  parameter int PARTICLE_COUNT = 4096,
  parameter int AXIS_BINS      = 16,
  parameter int POSITION_BITS  = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  pclb_pkg::req_t                      req,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output pclb_pkg::rsp_t                      rsp,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pclb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pclb_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import pclb_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  pclb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pclb_dp #(
    .PARTICLE_COUNT (PARTICLE_COUNT),
    .AXIS_BINS      (AXIS_BINS),
    .POSITION_BITS  (POSITION_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_wr    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks particle_cell_list_builder: a table of directed items runs under
// the reset grid, then several random phases run under new grid settings.
// A cycle-free model of the bin lists predicts each result that the table does
// not give; each is compared field by field, in order, with what the block returns.
// ----------------------------------------------------------------------------
module testbench;
  import pclb_pkg::*;

  localparam logic [POS_W-1:0] PMAX = '1;
  localparam int DIR_ROWS = 24;

  typedef struct packed {
    req_t item;
    logic typed;
    rsp_t want;
  } drow_t;

  logic                  clk;
  logic                  rst;
  logic                  req_valid;
  logic                  req_ready;
  req_t                  req;
  logic                  rsp_valid;
  logic                  rsp_ready;
  rsp_t                  rsp;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic [BINS_W-1:0]  bins_cfg[3];
  logic [SCALE_W-1:0] scale_cfg[3];
  logic [PID_W-1:0]   bin_first[4096];
  bit                 bin_used[4096];
  logic [ENTRY_W-1:0] chain_next[4096];
  bit                 placed[4096];
  logic [PID_W-1:0]   placed_q[$];
  logic [PID_W-1:0]   trail;
  bit                 trail_ok;
  rsp_t               due_rsp[$];
  drow_t              plan[DIR_ROWS];
  int                 fail_count;
  int                 send_idle_pct;
  int                 take_stall_pct;

  particle_cell_list_builder u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic req_t mk_req(input logic [1:0] f, input logic [PID_W-1:0] p,
                                  input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                  input logic [POS_W-1:0] z);
    req_t r;
    r.func = f;
    r.particle = p;
    r.pos_x = x;
    r.pos_y = y;
    r.pos_z = z;
    return r;
  endfunction

  function automatic rsp_t mk_rsp(input logic [PID_W-1:0] echo, input logic [3:0] cx,
                                  input logic [3:0] cy, input logic [3:0] cz,
                                  input logic [PID_W-1:0] lnk, input logic lv,
                                  input logic cl);
    rsp_t r;
    r.echo_particle = echo;
    r.cell_x = cx;
    r.cell_y = cy;
    r.cell_z = cz;
    r.link = lnk;
    r.link_valid = lv;
    r.clamped = cl;
    return r;
  endfunction

  function automatic logic [BINS_W-1:0] bins_in_use(input logic [BINS_W-1:0] count);
    if (count == 0) return 5'd1;
    if (count > 5'd16) return 5'd16;
    return count;
  endfunction

  // floor(pos * scale) in Q16.32, saturated to the last bin in use
  function automatic logic [CELL_W-1:0] axis_bin(input logic [POS_W-1:0] pos,
                                                 input logic [SCALE_W-1:0] scale,
                                                 input logic [BINS_W-1:0] count,
                                                 inout bit sat);
    logic [47:0]       prod;
    logic [BINS_W-1:0] n;
    n = bins_in_use(count);
    prod = {24'd0, pos} * {24'd0, scale};
    if (prod[47:32] >= {11'd0, n}) begin
      sat = 1'b1;
      return 4'(n - 5'd1);
    end
    return prod[35:32];
  endfunction

  function automatic rsp_t bin_request(input req_t item);
    rsp_t             r;
    bit               sat;
    logic [11:0]      slot;
    r = '0;
    sat = 1'b0;
    case (item.func)
      FUNC_CLEAR: begin
        foreach (bin_used[i]) bin_used[i] = 1'b0;
      end
      FUNC_NEXT: begin
        r.echo_particle = item.particle;
        r.link_valid = chain_next[item.particle][PID_W];
        if (r.link_valid) r.link = chain_next[item.particle][PID_W-1:0];
      end
      default: begin
        r.echo_particle = item.particle;
        r.cell_x = axis_bin(item.pos_x, scale_cfg[0], bins_cfg[0], sat);
        r.cell_y = axis_bin(item.pos_y, scale_cfg[1], bins_cfg[1], sat);
        r.cell_z = axis_bin(item.pos_z, scale_cfg[2], bins_cfg[2], sat);
        r.clamped = sat;
        slot = {r.cell_z, r.cell_y, r.cell_x};
        if (bin_used[slot]) begin
          r.link_valid = 1'b1;
          r.link = bin_first[slot];
        end
        if (item.func == FUNC_INSERT) begin
          chain_next[item.particle] = {r.link_valid, r.link};
          bin_first[slot] = item.particle;
          bin_used[slot] = 1'b1;
          if (!placed[item.particle]) begin
            placed[item.particle] = 1'b1;
            placed_q.push_back(item.particle);
          end
        end
      end
    endcase
    return r;
  endfunction

  // mostly aim at a chosen bin (one past the end to hit saturation)
  function automatic logic [POS_W-1:0] pick_pos(input int axis);
    logic [63:0]       target;
    logic [BINS_W-1:0] n;
    int                m;
    n = bins_in_use(bins_cfg[axis]);
    m = $urandom_range(99);
    if (m < 10) return $urandom_range(1) ? PMAX : '0;
    if (m < 30 || scale_cfg[axis] == 0) return POS_W'($urandom);
    target = {32'($urandom_range(0, n)), 32'($urandom)};
    target = target / {40'd0, scale_cfg[axis]};
    if (target > 64'(PMAX)) return POS_W'($urandom);
    return target[POS_W-1:0];
  endfunction

  function automatic req_t random_item();
    req_t it;
    int   m;
    it.particle = PID_W'($urandom);
    it.pos_x = pick_pos(0);
    it.pos_y = pick_pos(1);
    it.pos_z = pick_pos(2);
    m = $urandom_range(99);
    if (m < 3) begin
      it.func = FUNC_CLEAR;
    end else if (m < 50 || placed_q.size() == 0) begin
      it.func = FUNC_INSERT;
      if ($urandom_range(3) == 0 && placed_q.size() != 0)
        it.particle = placed_q[$urandom_range(0, placed_q.size() - 1)];
    end else if (m < 70) begin
      it.func = FUNC_HEAD;
    end else begin
      it.func = FUNC_NEXT;
      if (trail_ok && $urandom_range(1) == 1) it.particle = trail;
      else it.particle = placed_q[$urandom_range(0, placed_q.size() - 1)];
    end
    return it;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_bins();
    int                m;
    logic [BINS_W-1:0] count;
    m = $urandom_range(9);
    if (m < 6) count = 5'($urandom_range(1, 4));
    else if (m < 9) count = 5'($urandom_range(1, 16));
    else count = 5'($urandom_range(0, 31));
    return {($urandom_range(1) == 1) ? 19'($urandom) : 19'd0, count};
  endfunction

  function automatic logic [SCALE_W-1:0] rand_scale();
    if ($urandom_range(9) < 2) return SCALE_W'($urandom);
    return SCALE_W'($urandom_range(24'h2000, 24'h60000));
  endfunction

  task automatic report(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic field_check(input string name, input logic [PID_W-1:0] got,
                             input logic [PID_W-1:0] want);
    if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (due_rsp.size() == 0) begin
        report("result with no request outstanding");
      end else begin
        field_check("echo_particle", rsp.echo_particle, due_rsp[0].echo_particle);
        field_check("cell_x", 12'(rsp.cell_x), 12'(due_rsp[0].cell_x));
        field_check("cell_y", 12'(rsp.cell_y), 12'(due_rsp[0].cell_y));
        field_check("cell_z", 12'(rsp.cell_z), 12'(due_rsp[0].cell_z));
        field_check("link", rsp.link, due_rsp[0].link);
        field_check("link_valid", 12'(rsp.link_valid), 12'(due_rsp[0].link_valid));
        field_check("clamped", 12'(rsp.clamped), 12'(due_rsp[0].clamped));
        void'(due_rsp.pop_front());
      end
    end
  end

  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ready = ($urandom_range(99) >= take_stall_pct);
    end
  end

  task automatic send_req(input req_t item, input logic typed, input rsp_t want);
    rsp_t got;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid = 1'b1;
    req = item;
    do @(posedge clk); while (!req_ready);
    got = bin_request(item);
    due_rsp.push_back(typed ? want : got);
    if (item.func != FUNC_CLEAR) begin
      trail_ok = got.link_valid;
      trail = got.link;
    end
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BINS_X:  bins_cfg[0] = data[BINS_W-1:0];
      REG_BINS_Y:  bins_cfg[1] = data[BINS_W-1:0];
      REG_BINS_Z:  bins_cfg[2] = data[BINS_W-1:0];
      REG_SCALE_X: scale_cfg[0] = data;
      REG_SCALE_Y: scale_cfg[1] = data;
      REG_SCALE_Z: scale_cfg[2] = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_grid(input logic [CFG_DATA_W-1:0] bx, input logic [CFG_DATA_W-1:0] by,
                          input logic [CFG_DATA_W-1:0] bz, input logic [CFG_DATA_W-1:0] sx,
                          input logic [CFG_DATA_W-1:0] sy, input logic [CFG_DATA_W-1:0] sz);
    write_reg(REG_BINS_X, bx);
    write_reg(REG_BINS_Y, by);
    write_reg(REG_BINS_Z, bz);
    write_reg(REG_SCALE_X, sx);
    write_reg(REG_SCALE_Y, sy);
    write_reg(REG_SCALE_Z, sz);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    req_valid = 1'b0;
    while (due_rsp.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    #4ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_BINS_X;
    cfg_data = '0;
    fail_count = 0;
    send_idle_pct = 12;
    take_stall_pct = 12;
    trail_ok = 1'b0;
    trail = '0;
    bins_cfg = '{BINS_RESET, BINS_RESET, BINS_RESET};
    scale_cfg = '{SCALE_RESET, SCALE_RESET, SCALE_RESET};
    foreach (bin_used[i]) begin
      bin_used[i] = 1'b0;
      bin_first[i] = '0;
      chain_next[i] = '0;
      placed[i] = 1'b0;
    end

    // reset grid: 16 bins per axis, one bin per unit length
    plan = '{
      {mk_req(FUNC_CLEAR, 12'hABC, PMAX, PMAX, PMAX), 1'b1,
       mk_rsp(12'h000, 4'h0, 4'h0, 4'h0, 12'h000, 1'b0, 1'b0)},
      {mk_req(FUNC_HEAD, 12'h000, 24'h0, 24'h0, 24'h0), 1'b1,
       mk_rsp(12'h000, 4'h0, 4'h0, 4'h0, 12'h000, 1'b0, 1'b0)},
      {mk_req(FUNC_HEAD, 12'hFFF, PMAX, PMAX, PMAX), 1'b1,
       mk_rsp(12'hFFF, 4'hF, 4'hF, 4'hF, 12'h000, 1'b0, 1'b1)},
      {mk_req(FUNC_INSERT, 12'h000, 24'h0, 24'h0, 24'h0), 1'b1,
       mk_rsp(12'h000, 4'h0, 4'h0, 4'h0, 12'h000, 1'b0, 1'b0)},
      {mk_req(FUNC_INSERT, 12'hFFF, 24'h0, 24'h0, 24'h0), 1'b1,
       mk_rsp(12'hFFF, 4'h0, 4'h0, 4'h0, 12'h000, 1'b1, 1'b0)},
      {mk_req(FUNC_HEAD, 12'h123, 24'h0, 24'h0, 24'h0), 1'b1,
       mk_rsp(12'h123, 4'h0, 4'h0, 4'h0, 12'hFFF, 1'b1, 1'b0)},
      {mk_req(FUNC_NEXT, 12'hFFF, PMAX, PMAX, PMAX), 1'b1,
       mk_rsp(12'hFFF, 4'h0, 4'h0, 4'h0, 12'h000, 1'b1, 1'b0)},
      {mk_req(FUNC_NEXT, 12'h000, 24'h0, 24'h0, 24'h0), 1'b1,
       mk_rsp(12'h000, 4'h0, 4'h0, 4'h0, 12'h000, 1'b0, 1'b0)},
      {mk_req(FUNC_INSERT, 12'h555, PMAX, PMAX, PMAX), 1'b1,
       mk_rsp(12'h555, 4'hF, 4'hF, 4'hF, 12'h000, 1'b0, 1'b1)},
      {mk_req(FUNC_INSERT, 12'hAAA, PMAX, 24'h0, 24'h0A8000), 1'b0, rsp_t'('0)},
      {mk_req(FUNC_INSERT, 12'h001, 24'h0FFFFF, 24'h0FFFFF, 24'h0FFFFF), 1'b0, rsp_t'('0)},
      {mk_req(FUNC_INSERT, 12'h002, 24'h100000, 24'h0FFFFF, 24'h0FFFFF), 1'b0, rsp_t'('0)},
      {mk_req(FUNC_HEAD, 12'h000, 24'h0FFFFF, 24'h0FFFFF, 24'h0FFFFF), 1'b0, rsp_t'('0)},
      {mk_req(FUNC_CLEAR, 12'hFFF, 24'h0, 24'h0, 24'h0), 1'b1,
       mk_rsp(12'h000, 4'h0, 4'h0, 4'h0, 12'h000, 1'b0, 1'b0)},
      {mk_req(FUNC_HEAD, 12'h000, 24'h0, 24'h0, 24'h0), 1'b1,
       mk_rsp(12'h000, 4'h0, 4'h0, 4'h0, 12'h000, 1'b0, 1'b0)},
      {mk_req(FUNC_NEXT, 12'hFFF, 24'h0, 24'h0, 24'h0), 1'b1,
       mk_rsp(12'hFFF, 4'h0, 4'h0, 4'h0, 12'h000, 1'b1, 1'b0)},
      {mk_req(FUNC_INSERT, 12'h007, 24'h0, 24'h0, 24'h0), 1'b1,
       mk_rsp(12'h007, 4'h0, 4'h0, 4'h0, 12'h000, 1'b0, 1'b0)},
      {mk_req(FUNC_NEXT, 12'h007, 24'h0, 24'h0, 24'h0), 1'b1,
       mk_rsp(12'h007, 4'h0, 4'h0, 4'h0, 12'h000, 1'b0, 1'b0)},
      {mk_req(FUNC_INSERT, 12'h008, 24'h030000, 24'h050000, 24'h078000), 1'b0, rsp_t'('0)},
      {mk_req(FUNC_INSERT, 12'h009, 24'h030000, 24'h050000, 24'h078000), 1'b0, rsp_t'('0)},
      {mk_req(FUNC_NEXT, 12'h009, 24'h0, 24'h0, 24'h0), 1'b0, rsp_t'('0)},
      {mk_req(FUNC_HEAD, 12'h000, 24'h03FFFF, 24'h05FFFF, 24'h07FFFF), 1'b0, rsp_t'('0)},
      {mk_req(FUNC_INSERT, 12'hFFF, 24'h0, 24'h0, 24'h0), 1'b0, rsp_t'('0)},
      {mk_req(FUNC_NEXT, 12'hFFF, 24'h0, 24'h0, 24'h0), 1'b0, rsp_t'('0)}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) send_req(plan[i].item, plan[i].typed, plan[i].want);
    drain();

    for (int ph = 1; ph <= 7; ph++) begin
      case (ph)
        1: set_grid(24'd1, 24'd16, 24'd0, 24'hFFFFFF, 24'h010000, 24'h000000);
        2: set_grid(24'd31, 24'd4, 24'd2, 24'h004000, 24'h010000, 24'h028000);
        default: set_grid(rand_bins(), rand_bins(), rand_bins(),
                          rand_scale(), rand_scale(), rand_scale());
      endcase
      send_idle_pct = (ph == 4) ? 0 : 12;
      take_stall_pct = (ph == 4) ? 0 : 12;
      repeat (80) send_req(random_item(), 1'b0, rsp_t'('0));
      drain();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
